/* rtl/mic_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mic_pkg : shared types and codes of the multiset intersection counter
// Operation and status codes, and the request word that walks the cell chain.
// ----------------------------------------------------------------------------
package mic_pkg;

    localparam int KEY_BITS    = 32;
    localparam int OP_BITS     = 2;
    localparam int STATUS_BITS = 3;

    // operation codes
    localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_BITS-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_PROBE = 2'd2;
    localparam logic [OP_BITS-1:0] OP_NONE  = 2'd3;

    // status codes
    localparam logic [STATUS_BITS-1:0] ST_CLEARED   = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_LOADED    = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_MATCHED   = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_UNMATCHED = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd4;

    // request moving from cell to cell; done marks that a cell took it
    typedef struct packed {
        logic                valid;
        logic [OP_BITS-1:0]  op;
        logic [KEY_BITS-1:0] key;
        logic                done;
    } t_req;

endpackage

/* rtl/mic_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mic_cell : one table entry of the counting chain
// Holds one key and its count, serves the request passing by and hands the
// request on to the next cell through its request register.
// ----------------------------------------------------------------------------
module mic_cell #(
    parameter int COUNT_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_advance,
    input  mic_pkg::t_req i_req,
    output mic_pkg::t_req o_req
);

    logic                          r_valid;
    logic                          n_valid;
    logic [mic_pkg::KEY_BITS-1:0]  r_key;
    logic [mic_pkg::KEY_BITS-1:0]  n_key;
    logic [COUNT_BITS-1:0]         r_count;
    logic [COUNT_BITS-1:0]         n_count;
    mic_pkg::t_req                 r_req;
    mic_pkg::t_req                 n_req;
    logic                          w_match;

    assign w_match = r_valid && (r_key == i_req.key);

    // serve the passing request against this entry
    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_count = r_count;
        n_req   = i_req;
        if (i_req.valid) begin
            case (i_req.op)
                mic_pkg::OP_CLEAR: begin
                    n_valid = 1'b0;
                end
                mic_pkg::OP_LOAD: begin
                    if (!i_req.done) begin
                        if (w_match) begin
                            if (r_count != {COUNT_BITS{1'b1}}) begin
                                n_count = r_count + COUNT_BITS'(1);
                            end
                            n_req.done = 1'b1;
                        end else if (!r_valid) begin
                            // first free entry: claim it
                            n_valid    = 1'b1;
                            n_key      = i_req.key;
                            n_count    = COUNT_BITS'(1);
                            n_req.done = 1'b1;
                        end
                    end
                end
                mic_pkg::OP_PROBE: begin
                    if (!i_req.done && w_match && (r_count != '0)) begin
                        n_count    = r_count - COUNT_BITS'(1);
                        n_req.done = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // advance entry and request together; hold while the output stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_req.valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= n_valid;
            r_key   <= n_key;
            r_count <= n_count;
            r_req   <= n_req;
        end
    end

    assign o_req = r_req;

endmodule

/* rtl/multiset_intersection_counter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiset_intersection_counter : key-to-count table for multiset intersection
// Loads count values of a first multiset, probes match values of a second one
// and use up one count per match. The table is a chain of entry cells.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  request   i_valid o_ready i_operation i_element_value   in
//  result    o_valid i_ready o_result_value o_status       out
//
//  Each request walks the chain one cell per cycle unless a result stalls;
//  its result is registered after the last cell. Unless stalled, a new request
//  may enter every cycle, so the sustained rate is one request per cycle.
//  Reset empties the table at once (entry valid bits in every cell).
//  A stalled result freezes the whole chain and holds o_ready low.
//  An operation code with no meaning is accepted and gives no result.
// ----------------------------------------------------------------------------
module multiset_intersection_counter #(
    parameter int TABLE_ENTRIES = 64,
    parameter int COUNT_BITS    = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic        [mic_pkg::OP_BITS-1:0]     i_operation,
    input  logic signed [mic_pkg::KEY_BITS-1:0]    i_element_value,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [mic_pkg::KEY_BITS-1:0]    o_result_value,
    output logic        [mic_pkg::STATUS_BITS-1:0] o_status
);

    mic_pkg::t_req                      w_req [TABLE_ENTRIES+1];
    mic_pkg::t_req                      w_tail;
    logic                               w_advance;
    logic                               r_out_valid;
    logic [mic_pkg::KEY_BITS-1:0]       r_out_value;
    logic [mic_pkg::STATUS_BITS-1:0]    r_out_status;
    logic [mic_pkg::KEY_BITS-1:0]       n_out_value;
    logic [mic_pkg::STATUS_BITS-1:0]    n_out_status;

    // move the chain whenever the output register is free or being taken
    assign w_advance = !r_out_valid || i_ready;
    assign o_ready   = w_advance;

    // drop unused operation codes at the entry
    always_comb begin
        w_req[0].valid = i_valid && (i_operation != mic_pkg::OP_NONE);
        w_req[0].op    = i_operation;
        w_req[0].key   = i_element_value;
        w_req[0].done  = 1'b0;
    end

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        mic_cell #(
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (w_advance),
            .i_req     (w_req[g]),
            .o_req     (w_req[g+1])
        );
    end

    assign w_tail = w_req[TABLE_ENTRIES];

    // form the result from the request leaving the last cell
    always_comb begin
        n_out_value = w_tail.key;
        case (w_tail.op)
            mic_pkg::OP_CLEAR: begin
                n_out_value  = '0;
                n_out_status = mic_pkg::ST_CLEARED;
            end
            mic_pkg::OP_LOAD: begin
                n_out_status = w_tail.done ? mic_pkg::ST_LOADED : mic_pkg::ST_FULL;
            end
            mic_pkg::OP_PROBE: begin
                n_out_status = w_tail.done ? mic_pkg::ST_MATCHED : mic_pkg::ST_UNMATCHED;
            end
            default: begin
                n_out_status = mic_pkg::ST_UNMATCHED;
            end
        endcase
    end

    // hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid  <= w_tail.valid;
            r_out_value  <= n_out_value;
            r_out_status <= n_out_status;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;

endmodule

/* rtl/mic_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mic_checker : port-level checks of the multiset intersection counter
// Watches the top level's ports and flags stalls, reset and result slips.
// ----------------------------------------------------------------------------
module mic_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_valid,
    input logic                                   o_ready,
    input logic        [mic_pkg::OP_BITS-1:0]     i_operation,
    input logic signed [mic_pkg::KEY_BITS-1:0]    i_element_value,
    input logic                                   o_valid,
    input logic                                   i_ready,
    input logic signed [mic_pkg::KEY_BITS-1:0]    o_result_value,
    input logic        [mic_pkg::STATUS_BITS-1:0] o_status
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_value) && $stable(o_status))
        else $error("result changed while stalled");

    // a stalled result blocks new requests
    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("request taken while result stalled");

    // a clear reports the value zero
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == mic_pkg::ST_CLEARED) |-> (o_result_value == '0))
        else $error("clear result not zero");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid)
        else $error("result present after reset");

endmodule

bind multiset_intersection_counter mic_checker u_mic_checker (.*);
